// ===== hw/rtl/dwm_pkg.sv =====
// dwm_pkg: shared sizes, register codes, stage types and the tanh table
// for the drive waveshaper mix block; no dependencies
`timescale 1ns / 1ps

package dwm_pkg;

    localparam int SAMPLE_BITS      = 16;
    localparam int TANH_TABLE_DEPTH = 256;
    localparam int LOG2_DEPTH       = $clog2(TANH_TABLE_DEPTH);

    // Q1.8 unity for amount and mix
    localparam int Q08_ONE  = 256;
    localparam int CFG_W    = 9;
    localparam int CFG_IDX_W = 2;

    localparam longint ONE  = 64'sd1 <<< (SAMPLE_BITS - 1);

    // magnitude of a sample, gain and their product
    localparam int MAG_W    = SAMPLE_BITS + 1;
    localparam int GAIN_W   = 12;
    localparam int M_W      = SAMPLE_BITS + 11;
    localparam int FRAC_BITS = SAMPLE_BITS + 7;
    localparam int FRAC_W   = 16;
    localparam int WET_W    = SAMPLE_BITS + 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DRIVE_MODE   = 2'd0,
        CFG_DRIVE_AMOUNT = 2'd1,
        CFG_WET_MIX      = 2'd2
    } t_cfg_idx;

    // shaper modes
    localparam logic MODE_SOFT = 1'b0;
    localparam logic MODE_HARD = 1'b1;

    typedef struct packed {
        logic             valid;
        logic             neg;
        logic [M_W-1:0]   mag;
    } t_shp_req;

    typedef struct packed {
        logic                    valid;
        logic signed [WET_W-1:0] wet;
    } t_shp_rsp;

    typedef logic [SAMPLE_BITS-1:0] t_rom [TANH_TABLE_DEPTH+1];

    // shift-subtract division, used only while building the table
    function automatic logic [63:0] div_u64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] quo;
        logic [63:0] rem;
        quo = '0;
        rem = '0;
        for (int k = 63; k >= 0; k--) begin
            rem = {rem[62:0], num[k]};
            if (rem >= den) begin
                rem    = rem - den;
                quo[k] = 1'b1;
            end
        end
        return quo;
    endfunction

    // round(ONE * tanh(4*i/depth)) in q30 integers, exp from taylor terms
    function automatic logic [63:0] tanh_entry(input int i);
        logic [63:0] q30;
        logic [63:0] one_s;
        logic [63:0] t;
        logic [63:0] u;
        logic [63:0] u2;
        logic [63:0] u3;
        logic [63:0] u4;
        logic [63:0] y;
        q30   = 64'd1 << 30;
        one_s = 64'd1 << (SAMPLE_BITS - 1);
        t     = ((64'(8) * 64'(i)) << 30) / TANH_TABLE_DEPTH;
        u     = t >> 8;
        u2    = (u * u) >> 30;
        u3    = (u2 * u) >> 30;
        u4    = (u3 * u) >> 30;
        y     = (q30 - u) + u2 / 2 - u3 / 6 + u4 / 24;
        if (y > q30) begin
            y = q30;
        end
        for (int k = 0; k < 8; k++) begin
            y = (y * y + (64'd1 << 29)) >> 30;
        end
        return div_u64((q30 - y) * one_s + ((q30 + y) >> 1), q30 + y);
    endfunction

    function automatic t_rom build_rom();
        t_rom r;
        for (int i = 0; i <= TANH_TABLE_DEPTH; i++) begin
            r[i] = SAMPLE_BITS'(tanh_entry(i));
        end
        return r;
    endfunction

    localparam t_rom TANH_ROM = build_rom();

endpackage

// ===== hw/rtl/drive_waveshaper_mix.sv =====
// drive_waveshaper_mix: drive gain, soft or hard shaper and wet/dry mix
// depends on dwm_pkg and dwm_shaper
`timescale 1ns / 1ps
// result: a request taken at a clock edge passes through registered stages 0 to 5 and
//   then shows its result on o_sample_out with o_valid high for one cycle
// throughput: one sample per clock, set by a six-register pipeline with no feedback;
//   busy stays low and the receiver cannot stall
// reset (synchronous, active low): pipeline valid bits clear, drive_mode soft,
//   drive_amount 0, wet_mix 256 (fully wet)

module drive_waveshaper_mix (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                i_cfg_we,
    input  logic [dwm_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [dwm_pkg::CFG_W-1:0]           i_cfg_wdata,
    input  logic signed [dwm_pkg::SAMPLE_BITS-1:0] i_sample_in,
    output logic                                o_valid,
    output logic signed [dwm_pkg::SAMPLE_BITS-1:0] o_sample_out
);
    import dwm_pkg::*;

    localparam int PROD_W   = SAMPLE_BITS + 11;
    localparam int ACC_W    = PROD_W + 1;
    localparam int RND_HALF = 128;

    // configuration registers, values above unity are stored clamped
    logic         r_mode;
    logic [CFG_W-1:0] r_amount;
    logic [CFG_W-1:0] r_mix;
    logic [CFG_W-1:0] wdata_sat;

    assign wdata_sat = (i_cfg_wdata > CFG_W'(Q08_ONE)) ? CFG_W'(Q08_ONE) : i_cfg_wdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_SOFT;
            r_amount <= '0;
            r_mix    <= CFG_W'(Q08_ONE);
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_DRIVE_MODE:   r_mode   <= i_cfg_wdata[0];
                CFG_DRIVE_AMOUNT: r_amount <= wdata_sat;
                CFG_WET_MIX:      r_mix    <= wdata_sat;
                default:          ;  // unmapped index, ignored
            endcase
        end
    end

    // never stalls, a request is taken in every cycle it is offered
    assign busy = 1'b0;

    // stage 0: capture the request
    logic                          r0_valid;
    logic signed [SAMPLE_BITS-1:0] r0_sample;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_valid <= 1'b0;
        end else begin
            r0_valid <= start && !busy;
        end
        r0_sample <= i_sample_in;
    end

    // stage 1: magnitude times gain, gain = 256 + 9*amount in q4.8
    logic [SAMPLE_BITS:0]   sext;
    logic                   n_neg;
    logic [MAG_W-1:0]       n_mag;
    logic [GAIN_W-1:0]      gain;
    logic [MAG_W+GAIN_W-1:0] n_prod;
    t_shp_req               r1_req;
    logic signed [SAMPLE_BITS-1:0] r1_dry;

    assign sext   = {r0_sample[SAMPLE_BITS-1], r0_sample};
    assign n_neg  = r0_sample[SAMPLE_BITS-1];
    // full-scale negative maps to +1.0, which needs the extra bit
    assign n_mag  = n_neg ? (~sext + MAG_W'(1)) : sext;
    assign gain   = GAIN_W'(Q08_ONE) + GAIN_W'({r_amount, 3'b000}) + GAIN_W'(r_amount);
    assign n_prod = n_mag * gain;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_req.valid <= 1'b0;
        end else begin
            r1_req.valid <= r0_valid;
        end
        r1_req.neg <= n_neg;
        r1_req.mag <= n_prod[M_W-1:0];
        r1_dry     <= r0_sample;
    end

    // stages 2 and 3: shaper, dry sample delayed alongside
    t_shp_rsp                      shp_rsp;
    logic signed [SAMPLE_BITS-1:0] r2_dry;
    logic signed [SAMPLE_BITS-1:0] r3_dry;

    dwm_shaper u_shaper (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_mode  (r_mode),
        .i_req   (r1_req),
        .o_rsp   (shp_rsp)
    );

    always_ff @(posedge i_clk) begin
        r2_dry <= r1_dry;
        r3_dry <= r2_dry;
    end

    // stage 4: wet and dry weights
    logic [CFG_W-1:0]         inv_mix;
    logic signed [PROD_W-1:0] n_pw;
    logic signed [PROD_W-1:0] n_pd;
    logic                     r4_valid;
    logic signed [PROD_W-1:0] r4_pw;
    logic signed [PROD_W-1:0] r4_pd;

    assign inv_mix = CFG_W'(Q08_ONE) - r_mix;
    assign n_pw    = shp_rsp.wet * $signed({1'b0, r_mix});
    assign n_pd    = r3_dry * $signed({1'b0, inv_mix});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_valid <= 1'b0;
        end else begin
            r4_valid <= shp_rsp.valid;
        end
        r4_pw <= n_pw;
        r4_pd <= n_pd;
    end

    // stage 5: sum, round half up, saturate into the output register
    logic signed [ACC_W-1:0]       acc;
    logic signed [ACC_W-1:0]       res;
    logic signed [SAMPLE_BITS-1:0] n_out;
    logic                          r_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_out;

    assign acc = ACC_W'(r4_pw) + ACC_W'(r4_pd) + ACC_W'(RND_HALF);
    assign res = acc >>> 8;

    always_comb begin
        priority if (res > ACC_W'(ONE - 1)) begin
            n_out = SAMPLE_BITS'(ONE - 1);
        end else if (res < ACC_W'(-ONE)) begin
            n_out = SAMPLE_BITS'(-ONE);
        end else begin
            n_out = res[SAMPLE_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= r4_valid;
        end
        r_out <= n_out;
    end

    assign o_valid      = r_out_valid;
    assign o_sample_out = r_out;

    a_out_needs_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, 6))
        else $error("result strobe without a request six cycles earlier");

    a_dry_passthrough: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && $past(r_mix, 2) == '0) |-> o_sample_out == $past(r3_dry, 2))
        else $error("zero mix did not pass the dry sample");

endmodule

// ===== hw/rtl/dwm_shaper.sv =====
// dwm_shaper: two-stage waveshaper, tanh table with interpolation or hard clamp
// depends on dwm_pkg (sizes, request types, tanh table)
`timescale 1ns / 1ps

module dwm_shaper (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_mode,
    input  dwm_pkg::t_shp_req i_req,
    output dwm_pkg::t_shp_rsp o_rsp
);
    import dwm_pkg::*;

    localparam int P_W   = M_W + LOG2_DEPTH;
    localparam int IDX_W = LOG2_DEPTH + 2;
    localparam int HW_W  = M_W - 8;
    localparam int RI_W  = LOG2_DEPTH + 1;

    // stage a: table lookup and clamp
    logic [P_W-1:0]         p;
    logic [IDX_W-1:0]       idx_full;
    logic [LOG2_DEPTH-1:0]  idx;
    logic [RI_W-1:0]        ri_a;
    logic [RI_W-1:0]        ri_b;
    logic [SAMPLE_BITS-1:0] rom_a;
    logic [SAMPLE_BITS-1:0] rom_b;
    logic                   n_sat;
    logic [SAMPLE_BITS-1:0] n_base;
    logic [SAMPLE_BITS-1:0] n_diff;
    logic [FRAC_W-1:0]      n_frac;
    logic [HW_W-1:0]        hw;
    logic [SAMPLE_BITS-1:0] n_hard;

    logic                   r_a_valid;
    logic                   r_a_neg;
    logic                   r_a_mode;
    logic                   r_a_sat;
    logic [SAMPLE_BITS-1:0] r_a_base;
    logic [SAMPLE_BITS-1:0] r_a_diff;
    logic [FRAC_W-1:0]      r_a_frac;
    logic [SAMPLE_BITS-1:0] r_a_hard;

    assign p        = {i_req.mag, {LOG2_DEPTH{1'b0}}};
    assign idx_full = p[P_W-1 -: IDX_W];
    assign idx      = idx_full[LOG2_DEPTH-1:0];
    assign n_sat    = |idx_full[IDX_W-1:LOG2_DEPTH];
    assign n_frac   = p[SAMPLE_BITS-7 +: FRAC_W];
    assign ri_a     = {1'b0, idx};
    assign ri_b     = ri_a + RI_W'(1);
    assign rom_a    = TANH_ROM[ri_a];
    assign rom_b    = TANH_ROM[ri_b];
    assign hw       = i_req.mag[M_W-1:8];

    always_comb begin
        if (n_sat) begin
            n_base = TANH_ROM[TANH_TABLE_DEPTH];
            n_diff = '0;
        end else begin
            n_base = rom_a;
            n_diff = (rom_b > rom_a) ? (rom_b - rom_a) : '0;
        end
        if (hw > HW_W'(ONE)) begin
            n_hard = SAMPLE_BITS'(ONE);
        end else begin
            n_hard = hw[SAMPLE_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else begin
            r_a_valid <= i_req.valid;
        end
        r_a_neg  <= i_req.neg;
        r_a_mode <= i_mode;
        r_a_sat  <= n_sat;
        r_a_base <= n_base;
        r_a_diff <= n_diff;
        r_a_frac <= n_frac;
        r_a_hard <= n_hard;
    end

    // stage b: interpolate, select, apply sign
    logic [SAMPLE_BITS+FRAC_W-1:0] prod;
    logic [SAMPLE_BITS-1:0]        interp;
    logic [SAMPLE_BITS-1:0]        w;
    logic signed [WET_W-1:0]       n_wet;
    logic                          r_b_valid;
    logic signed [WET_W-1:0]       r_b_wet;

    assign prod   = r_a_diff * r_a_frac + (SAMPLE_BITS+FRAC_W)'(1 << (FRAC_W - 1));
    assign interp = prod[SAMPLE_BITS+FRAC_W-1:FRAC_W];

    always_comb begin
        if (r_a_mode == MODE_HARD) begin
            w = r_a_hard;
        end else begin
            w = r_a_base + interp;
        end
        n_wet = r_a_neg ? -$signed({1'b0, w}) : $signed({1'b0, w});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else begin
            r_b_valid <= r_a_valid;
        end
        r_b_wet <= n_wet;
    end

    assign o_rsp = '{valid: r_b_valid, wet: r_b_wet};

    a_valid_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> $past(i_req.valid, 2))
        else $error("shaper valid out of step with request");

    a_soft_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_a_valid && r_a_sat && r_a_mode == MODE_SOFT && !r_a_neg)
        |=> o_rsp.wet == $signed({1'b0, TANH_ROM[TANH_TABLE_DEPTH]}))
        else $error("soft clip beyond range did not hold last table entry");

endmodule
